// ----- src/const_accel_motion_profile_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the motion profile unit
// Two forms: same-cycle implication and next-cycle implication, both
// clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONST_ACCEL_MOTION_PROFILE_UNIT_DEFINES_SVH
`define CONST_ACCEL_MOTION_PROFILE_UNIT_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define CMPU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define CMPU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/cmpu_pkg.sv -----
// ----------------------------------------------------------------------------
// cmpu_pkg
// Shared constants, types and helpers of the motion profile unit.
// ----------------------------------------------------------------------------
package cmpu_pkg;

	// default fraction bits of the velocity and acceleration results
	localparam int VEL_FRAC_DEF = 32;
	localparam int ACC_FRAC_DEF = 48;

	// field widths
	localparam int TW   = 33;   // sample time
	localparam int HW   = 32;   // height
	localparam int DURW = 32;   // duration
	localparam int FRW  = 17;   // Q0.16 fractions
	localparam int QW   = 64;   // quotient magnitude
	localparam int DW   = 98;   // widest denominator (EV*D)

	localparam logic [FRW-1:0] ONE_Q16 = 17'h10000;

	// multiplier limb width and unit latencies
	localparam int LIMB    = 32;
	localparam int MUL_LAT = 2;
	localparam int DIV_LAT = QW + 2;
	localparam int NL      = 3;   // divider lanes: position, velocity, acceleration

	// lane numbers
	localparam int LN_POS = 0;
	localparam int LN_VEL = 1;
	localparam int LN_ACC = 2;

	// register indexes
	localparam logic [1:0] REG_HEIGHT   = 2'd0;
	localparam logic [1:0] REG_DURATION = 2'd1;
	localparam logic [1:0] REG_ACC_END  = 2'd2;
	localparam logic [1:0] REG_DEC_BEG  = 2'd3;

	// segment codes
	localparam logic [1:0] SEG_ACC = 2'd0;
	localparam logic [1:0] SEG_CRU = 2'd1;
	localparam logic [1:0] SEG_DEC = 2'd2;

	// per-item control that travels beside the arithmetic
	typedef struct packed {
		logic          vld;
		logic          bad;    // unusable configuration
		logic          zero;   // outputs all zero
		logic          full;   // move finished: position is h
		logic [1:0]    seg;
		logic          hneg;
		logic [HW-1:0] hmag;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

	// sign a magnitude, saturating to the signed 64-bit range
	function automatic logic [QW-1:0] apply_sign(input logic [QW-1:0] mag, input logic neg);
		logic [QW-1:0] r;
		if (!neg)
			r = mag[QW-1] ? {1'b0, {(QW-1){1'b1}}} : mag;
		else
			r = mag[QW-1] ? {1'b1, {(QW-1){1'b0}}} : ({QW{1'b0}} - mag);
		return r;
	endfunction

endpackage

// ----- src/cmpu_dly.sv -----
// ----------------------------------------------------------------------------
// cmpu_dly
// Fixed delay line that keeps side data aligned with the arithmetic.
// ----------------------------------------------------------------------------
module cmpu_dly #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_s [N];

	// shift on every advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++)
				tap_s[i] <= '0;
		end else if (en) begin
			tap_s[0] <= din;
			for (int i = 1; i < N; i++)
				tap_s[i] <= tap_s[i-1];
		end
	end

	assign dout = tap_s[N-1];

endmodule

// ----- src/cmpu_mul.sv -----
// ----------------------------------------------------------------------------
// cmpu_mul
// Unsigned multiplier in two stages: limb partial products, then their sum.
// ----------------------------------------------------------------------------
module cmpu_mul import cmpu_pkg::*; #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic            clk,
	input  logic            en,
	input  logic [AW-1:0]   a,
	input  logic [BW-1:0]   b,
	output logic [AW+BW-1:0] p
);

	localparam int NA = (AW + LIMB - 1) / LIMB;
	localparam int NB = (BW + LIMB - 1) / LIMB;
	localparam int PW = AW + BW;

	logic [NA*LIMB-1:0]   a_pad;
	logic [NB*LIMB-1:0]   b_pad;
	logic [2*LIMB-1:0]    pp_s1 [NA][NB];
	logic [PW-1:0]        sum;
	logic [PW-1:0]        p_s2;

	assign a_pad = (NA*LIMB)'(a);
	assign b_pad = (NB*LIMB)'(b);

	// stage 1: limb by limb products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++)
				for (int j = 0; j < NB; j++)
					pp_s1[i][j] <= a_pad[i*LIMB +: LIMB] * b_pad[j*LIMB +: LIMB];
		end
	end

	// stage 2: weighted sum of the partial products
	always_comb begin
		sum = '0;
		for (int i = 0; i < NA; i++)
			for (int j = 0; j < NB; j++)
				sum = sum + (PW'(pp_s1[i][j]) << ((i + j) * LIMB));
	end

	always_ff @(posedge clk) begin
		if (en)
			p_s2 <= sum;
	end

	assign p = p_s2;

endmodule

// ----- src/cmpu_div.sv -----
// ----------------------------------------------------------------------------
// cmpu_div
// Pipelined restoring divider, one quotient bit per stage, three lanes over
// a shared denominator. Rounds half away from zero, saturates to all ones.
// ----------------------------------------------------------------------------
module cmpu_div import cmpu_pkg::*; #(
	parameter int NW = 145
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num [NL],
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo [NL]
);

	logic [DW-1:0] den_s [QW+1];
	logic [DW-1:0] rem_s [QW+1][NL];
	logic [QW-1:0] low_s [QW+1][NL];
	logic [QW-1:0] q_s   [QW+1][NL];
	logic [NL-1:0] ovf_s [QW+1];

	logic [DW-1:0] rem_n [QW][NL];
	logic [QW-1:0] q_n   [QW][NL];
	logic [QW-1:0] quo_q [NL];

	// one compare and subtract per stage and lane
	always_comb begin
		logic [DW:0] trial;
		logic        ge;
		for (int k = 0; k < QW; k++) begin
			for (int l = 0; l < NL; l++) begin
				trial = {rem_s[k][l], low_s[k][l][QW-1]};
				ge    = trial >= {1'b0, den_s[k]};
				rem_n[k][l] = ge ? DW'(trial - {1'b0, den_s[k]}) : trial[DW-1:0];
				q_n[k][l]   = {q_s[k][l][QW-2:0], ge};
			end
		end
	end

	// entry stage, bit stages and rounding stage
	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den;
			for (int l = 0; l < NL; l++) begin
				// quotient fits only if the top part is below the divisor
				ovf_s[0][l] <= num[l][NW-1:QW] >= den;
				rem_s[0][l] <= DW'(num[l][NW-1:QW]);
				low_s[0][l] <= num[l][QW-1:0];
				q_s[0][l]   <= '0;
			end
			for (int k = 0; k < QW; k++) begin
				den_s[k+1] <= den_s[k];
				ovf_s[k+1] <= ovf_s[k];
				for (int l = 0; l < NL; l++) begin
					rem_s[k+1][l] <= rem_n[k][l];
					low_s[k+1][l] <= low_s[k][l] << 1;
					q_s[k+1][l]   <= q_n[k][l];
				end
			end
			for (int l = 0; l < NL; l++) begin
				if (ovf_s[QW][l])
					quo_q[l] <= '1;
				else if (({rem_s[QW][l], 1'b0} >= {1'b0, den_s[QW]}) && (q_s[QW][l] != '1))
					quo_q[l] <= q_s[QW][l] + 1'b1;
				else
					quo_q[l] <= q_s[QW][l];
			end
		end
	end

	assign quo = quo_q;

endmodule

// ----- src/const_accel_motion_profile_unit.sv -----
// ----------------------------------------------------------------------------
// const_accel_motion_profile_unit
// Trapezoidal velocity move: position, velocity and acceleration per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Write height, duration and the two Q0.16 fractions through cfg_wr_en,
//   cfg_index and cfg_data while no item is in flight. Then stream sample
//   times on sample_valid / sample_stall; each item gives one result on
//   result_valid / result_stall with position, velocity, acceleration and
//   bad_config.
//   From acceptance to result_valid an item passes three set-up
//   stages, two two-stage multiplies in series, then the 66-stage divider
//   (one quotient bit per stage) and an output register. Throughput is
//   one item per cycle unless stalled; the divider pipeline is the long pole.
//   While a result is held by result_stall the whole pipeline freezes and
//   sample_stall is raised; nothing is dropped or repeated.
//   Reset clears every valid bit and loads h = 0, duration 1 and both
//   fractions to one half.
// ----------------------------------------------------------------------------
`include "const_accel_motion_profile_unit_defines.svh"

module const_accel_motion_profile_unit import cmpu_pkg::*; #(
	parameter int VEL_FRAC = VEL_FRAC_DEF,
	parameter int ACC_FRAC = ACC_FRAC_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic signed [TW-1:0] sample_time,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic signed [31:0]   position,
	output logic signed [63:0]   velocity,
	output logic signed [63:0]   acceleration,
	output logic                 bad_config
);

	localparam int VSH = 17 + VEL_FRAC;
	localparam int ASH = 33 + ACC_FRAC;
	localparam int NW0 = (HW + 48 + VSH > 128) ? HW + 48 + VSH : 128;
	localparam int NW  = (HW + 1 + ASH > NW0) ? HW + 1 + ASH : NW0;

	// configuration registers
	logic [HW-1:0]   height_q;
	logic [DURW-1:0] dur_q;
	logic [FRW-1:0]  av_q;
	logic [FRW-1:0]  aw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= '0;
			dur_q    <= 32'd1;
			av_q     <= 17'h08000;
			aw_q     <= 17'h08000;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_HEIGHT:   height_q <= cfg_data;
				REG_DURATION: dur_q    <= cfg_data;
				REG_ACC_END:  av_q     <= cfg_data[FRW-1:0];
				REG_DEC_BEG:  aw_q     <= cfg_data[FRW-1:0];
				default: ;
			endcase
		end
	end

	// global advance: freeze only while a result is held
	logic adv;
	assign adv          = !(result_valid && result_stall);
	assign sample_stall = !adv;

	// stage 1: classify the sample, scale times to Q16 ticks
	side_t         side_d1, side_s1;
	logic [47:0]   x_s1, e_s1;
	logic [48:0]   ev_s1, ew_s1;
	logic          bad_c, tneg_c, hneg_c;

	always_comb begin
		bad_c  = (av_q == '0) || (aw_q >= ONE_Q16) || (av_q > aw_q) || (dur_q == '0);
		tneg_c = sample_time[TW-1];
		hneg_c = height_q[HW-1];
		side_d1.vld  = sample_valid;
		side_d1.bad  = bad_c;
		side_d1.zero = bad_c || tneg_c || (sample_time == '0);
		side_d1.full = !tneg_c && (sample_time[31:0] >= dur_q);
		side_d1.seg  = SEG_ACC;
		side_d1.hneg = hneg_c;
		side_d1.hmag = hneg_c ? (~height_q + 1'b1) : height_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_s1 <= '0;
		else if (adv)
			side_s1 <= side_d1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1  <= {sample_time[31:0], 16'd0};
			e_s1  <= {dur_q, 16'd0};
			ev_s1 <= av_q * dur_q;
			ew_s1 <= aw_q * dur_q;
		end
	end

	// stage 2: segment boundaries and distances
	side_t       side_d2, side_s2;
	logic [48:0] d_s2, ev_s2, c_s2;
	logic [47:0] r_s2, rem_s2, x_s2;
	logic [49:0] d_w;
	logic [48:0] r_w;

	assign d_w = {2'b0, e_s1} + {1'b0, ew_s1} - {1'b0, ev_s1};
	assign r_w = {1'b0, e_s1} - ew_s1;

	// segment of the sample
	always_comb begin
		side_d2 = side_s1;
		if ({1'b0, x_s1} < ev_s1)
			side_d2.seg = SEG_ACC;
		else if ({1'b0, x_s1} <= ew_s1)
			side_d2.seg = SEG_CRU;
		else
			side_d2.seg = SEG_DEC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_s2 <= '0;
		else if (adv)
			side_s2 <= side_d2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2   <= d_w[48:0];
			r_s2   <= r_w[47:0];
			rem_s2 <= e_s1 - x_s1;
			x_s2   <= x_s1;
			ev_s2  <= ev_s1;
			c_s2   <= {x_s1, 1'b0} - ev_s1;
		end
	end

	// stage 3: pick multiplier operands for the segment
	side_t       side_s3;
	logic [48:0] m_s3, dd_s3, a1_s3;
	logic [47:0] a2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_s3 <= '0;
		else if (adv)
			side_s3 <= side_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dd_s3 <= d_s2;
			case (side_s2.seg)
				SEG_ACC: begin
					m_s3  <= ev_s2;
					a1_s3 <= {1'b0, x_s2};
					a2_s3 <= x_s2;
				end
				SEG_CRU: begin
					m_s3  <= 49'd1;
					a1_s3 <= c_s2;
					a2_s3 <= 48'd1;
				end
				default: begin
					m_s3  <= {1'b0, r_s2};
					a1_s3 <= {1'b0, rem_s2};
					a2_s3 <= rem_s2;
				end
			endcase
		end
	end

	// first multiply: denominator, squared distance, velocity base
	logic [97:0]  den_m;
	logic [96:0]  sq_m;
	logic [79:0]  vb_m;
	logic [SIDE_W-1:0] side_v5, side_v7, side_vo;
	side_t        side_s5, side_s7, side_o;

	cmpu_mul #(.AW(49), .BW(49)) u_mul_den (
		.clk(clk), .en(adv), .a(m_s3), .b(dd_s3), .p(den_m));
	cmpu_mul #(.AW(49), .BW(48)) u_mul_sq (
		.clk(clk), .en(adv), .a(a1_s3), .b(a2_s3), .p(sq_m));
	cmpu_mul #(.AW(HW), .BW(48)) u_mul_vb (
		.clk(clk), .en(adv), .a(side_s3.hmag), .b(a2_s3), .p(vb_m));

	cmpu_dly #(.W(SIDE_W), .N(MUL_LAT)) u_dly_side5 (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(side_s3), .dout(side_v5));
	assign side_s5 = side_t'(side_v5);

	// second multiply: height times squared distance
	logic [128:0] pn_m;
	logic [177:0] dv_m;

	cmpu_mul #(.AW(HW), .BW(97)) u_mul_pos (
		.clk(clk), .en(adv), .a(side_s5.hmag), .b(sq_m), .p(pn_m));

	cmpu_dly #(.W(178), .N(MUL_LAT)) u_dly_dv (
		.clk(clk), .arst_n(arst_n), .en(adv), .din({den_m, vb_m}), .dout(dv_m));
	cmpu_dly #(.W(SIDE_W), .N(MUL_LAT)) u_dly_side7 (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(side_v5), .dout(side_v7));
	assign side_s7 = side_t'(side_v7);

	// numerators and divide
	logic [NW-1:0] num_d [NL];
	logic [QW-1:0] quo   [NL];

	assign num_d[LN_POS] = NW'(pn_m);
	assign num_d[LN_VEL] = NW'(dv_m[79:0]) << VSH;
	assign num_d[LN_ACC] = NW'(side_s7.hmag) << ASH;

	cmpu_div #(.NW(NW)) u_div (
		.clk(clk), .en(adv), .num(num_d), .den(dv_m[177:80]), .quo(quo));

	cmpu_dly #(.W(SIDE_W), .N(DIV_LAT)) u_dly_sideo (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(side_v7), .dout(side_vo));
	assign side_o = side_t'(side_vo);

	// output stage: segment result, signs, special cases
	logic [31:0] hb_o, qc_o, pm_o, pos_d;
	logic [63:0] vel_d, acc_d;

	always_comb begin
		hb_o  = side_o.hneg ? (~side_o.hmag + 1'b1) : side_o.hmag;
		qc_o  = (quo[LN_POS] > QW'(side_o.hmag)) ? side_o.hmag : quo[LN_POS][31:0];
		pm_o  = side_o.hmag - qc_o;
		pos_d = '0;
		vel_d = '0;
		acc_d = '0;
		if (side_o.zero) begin
			pos_d = '0;
		end else if (side_o.full) begin
			pos_d = hb_o;
		end else begin
			vel_d = apply_sign(quo[LN_VEL], side_o.hneg);
			case (side_o.seg)
				SEG_ACC: begin
					pos_d = side_o.hneg ? (~quo[LN_POS][31:0] + 1'b1) : quo[LN_POS][31:0];
					acc_d = apply_sign(quo[LN_ACC], side_o.hneg);
				end
				SEG_CRU: begin
					pos_d = side_o.hneg ? (~quo[LN_POS][31:0] + 1'b1) : quo[LN_POS][31:0];
				end
				default: begin
					// deceleration: h minus the remaining travel
					pos_d = side_o.hneg ? (~pm_o + 1'b1) : pm_o;
					acc_d = apply_sign(quo[LN_ACC], !side_o.hneg);
				end
			endcase
		end
	end

	logic        out_vld_q, bad_q;
	logic [31:0] pos_q;
	logic [63:0] vel_q, acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (adv)
			out_vld_q <= side_o.vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_q <= pos_d;
			vel_q <= vel_d;
			acc_q <= acc_d;
			bad_q <= side_o.bad;
		end
	end

	assign result_valid = out_vld_q;
	assign position     = pos_q;
	assign velocity     = vel_q;
	assign acceleration = acc_q;
	assign bad_config   = bad_q;

	// checks
	`CMPU_ASSERT_IMP(a_bad_zero, result_valid && bad_config,
		position == 0 && velocity == 0 && acceleration == 0,
		"bad configuration gave nonzero motion")
	`CMPU_ASSERT_IMP(a_stall_src, sample_stall,
		result_valid && result_stall,
		"input stalled without a held result")
	`CMPU_ASSERT_NXT(a_move_done, adv && side_o.vld && side_o.full && !side_o.zero,
		result_valid && velocity == 0 && acceleration == 0 && position == $past(hb_o),
		"finished move did not rest at height")

endmodule
